// ===== rtl/core/prpu_pkg.sv =====
// Shared types and constants of the PCX run-length plane unpacker.
`default_nettype none
package prpu_pkg;

    localparam int ADDR_W     = 22;
    localparam int BYTE_W     = 8;
    localparam int RUN_W      = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int LW_W       = 11;
    localparam int LH_W       = 11;
    localparam int PLANE_W    = 2;

    localparam logic [BYTE_W-1:0] RUN_MARK   = 8'hC0;
    localparam logic [BYTE_W-1:0] COUNT_MASK = 8'h3F;

    localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_COUNT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LAYOUT_MODE  = 2'd3;

    typedef struct packed {
        logic take_byte;
        logic emit;
    } prpu_cmd_t;

    typedef struct packed {
        logic start_run;
        logic last_pixel;
        logic cfg_busy;
    } prpu_status_t;

endpackage
`default_nettype wire

// ===== rtl/core/prpu_code_if.sv =====
// Handshake channel that carries compressed code bytes.
`default_nettype none
interface prpu_code_if;
    logic                           valid;
    logic                           ready;
    logic [prpu_pkg::BYTE_W-1:0]    code_byte;

    modport source (output valid, output code_byte, input ready);
    modport sink (input valid, input code_byte, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/prpu_pixel_if.sv =====
// Handshake channel that carries decoded pixels with their frame-buffer addresses.
`default_nettype none
interface prpu_pixel_if;
    logic                           valid;
    logic                           ready;
    logic [prpu_pkg::ADDR_W-1:0]    write_address;
    logic [prpu_pkg::BYTE_W-1:0]    pixel_value;
    logic                           last_of_run;
    logic                           image_done;

    modport source (output valid, output write_address, output pixel_value,
                    output last_of_run, output image_done, input ready);
    modport sink (input valid, input write_address, input pixel_value,
                  input last_of_run, input image_done, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/prpu_ctrl.sv =====
// Controller state machine of the unpacker: byte intake and pixel emission.
`default_nettype none
module prpu_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   code_valid,
    output logic                        code_ready,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    input  wire prpu_pkg::prpu_status_t status,
    output prpu_pkg::prpu_cmd_t         cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic take;
    logic emit;

    assign code_ready = (state_reg == S_IDLE);
    assign take       = code_valid && code_ready;
    assign emit       = (state_reg == S_RUN) && (!out_valid_reg || out_ready)
                        && !status.cfg_busy;

    assign cmd.take_byte = take;
    assign cmd.emit      = emit;
    assign out_valid     = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (take && status.start_run)
                begin
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                if (emit && status.last_pixel)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/prpu_datapath.sv =====
// Datapath of the unpacker: configuration, decode state, addressing and result register.
`default_nettype none
module prpu_datapath #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [prpu_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [prpu_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic [prpu_pkg::BYTE_W-1:0]        code_byte,
    input  wire prpu_pkg::prpu_cmd_t                cmd,
    output prpu_pkg::prpu_status_t                  status,
    output logic [prpu_pkg::ADDR_W-1:0]             write_address,
    output logic [prpu_pkg::BYTE_W-1:0]             pixel_value,
    output logic                                    last_of_run,
    output logic                                    image_done
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int EW = $clog2(MAX_WIDTH + 1);
    localparam int EH = $clog2(MAX_HEIGHT + 1);
    localparam int AW = prpu_pkg::ADDR_W;

    logic [prpu_pkg::LW_W-1:0]      line_width_reg;
    logic [prpu_pkg::LH_W-1:0]      image_height_reg;
    logic [prpu_pkg::PLANE_W-1:0]   plane_count_reg;
    logic                           layout_mode_reg;
    logic                           cfg_busy_reg;
    logic [AW-1:0]                  plane_size_reg;

    logic                           value_pending_reg;
    logic [prpu_pkg::RUN_W-1:0]     run_length_reg;
    logic [prpu_pkg::RUN_W-1:0]     count_reg;
    logic [prpu_pkg::BYTE_W-1:0]    value_reg;
    logic [CW-1:0]                  column_reg;
    logic [prpu_pkg::PLANE_W-1:0]   plane_index_reg;
    logic [RW-1:0]                  row_index_reg;
    logic [AW-1:0]                  row_base_reg;
    logic                           finished_reg;

    logic [AW-1:0]                  addr_reg;
    logic [prpu_pkg::BYTE_W-1:0]    pixel_reg;
    logic                           last_reg;
    logic                           done_reg;

    logic [EW-1:0]                  eff_w;
    logic [EH-1:0]                  eff_h;
    logic [prpu_pkg::PLANE_W-1:0]   eff_p;
    logic                           is_header;
    logic [CW:0]                    col_inc;
    logic [prpu_pkg::PLANE_W-1:0]   plane_inc;
    logic [RW:0]                    row_inc;
    logic                           line_end;
    logic                           row_end;
    logic                           image_end;
    logic [AW-1:0]                  pos;
    logic [AW-1:0]                  plane_offset;
    logic [AW-1:0]                  address;

    always_comb
    begin
        if (line_width_reg == '0)
        begin
            eff_w = EW'(1);
        end
        else if (32'(line_width_reg) > MAX_WIDTH)
        begin
            eff_w = EW'(MAX_WIDTH);
        end
        else
        begin
            eff_w = EW'(line_width_reg);
        end
        if (image_height_reg == '0)
        begin
            eff_h = EH'(1);
        end
        else if (32'(image_height_reg) > MAX_HEIGHT)
        begin
            eff_h = EH'(MAX_HEIGHT);
        end
        else
        begin
            eff_h = EH'(image_height_reg);
        end
        eff_p = (plane_count_reg == '0) ? 2'd1 : plane_count_reg;
    end

    assign is_header = ((code_byte & prpu_pkg::RUN_MARK) == prpu_pkg::RUN_MARK);

    assign col_inc   = {1'b0, column_reg} + 1'b1;
    assign plane_inc = plane_index_reg + 1'b1;
    assign row_inc   = {1'b0, row_index_reg} + 1'b1;
    assign line_end  = (32'(col_inc) >= 32'(eff_w));
    assign row_end   = line_end && (plane_inc >= eff_p);
    assign image_end = row_end && (32'(row_inc) >= 32'(eff_h));

    assign pos = row_base_reg + AW'(column_reg);

    always_comb
    begin
        unique case (plane_index_reg)
            2'd0:    plane_offset = '0;
            2'd1:    plane_offset = plane_size_reg;
            2'd2:    plane_offset = {plane_size_reg[AW-2:0], 1'b0};
            default: plane_offset = {plane_size_reg[AW-2:0], 1'b0} + plane_size_reg;
        endcase
        if ((eff_p == 2'd3) && !layout_mode_reg)
        begin
            address = {pos[AW-3:0], 2'd2 - plane_index_reg};
        end
        else
        begin
            address = plane_offset + pos;
        end
    end

    assign status.start_run  = !finished_reg
                               && (value_pending_reg ? (run_length_reg != '0) : !is_header);
    assign status.last_pixel = (count_reg == prpu_pkg::RUN_W'(1)) || line_end;
    assign status.cfg_busy   = cfg_busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg   <= prpu_pkg::LW_W'(1);
            image_height_reg <= prpu_pkg::LH_W'(1);
            plane_count_reg  <= 2'd1;
            layout_mode_reg  <= 1'b0;
            cfg_busy_reg     <= 1'b0;
        end
        else
        begin
            cfg_busy_reg <= cfg_we;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    prpu_pkg::REG_LINE_WIDTH:
                        line_width_reg <= cfg_data;
                    prpu_pkg::REG_IMAGE_HEIGHT:
                        image_height_reg <= cfg_data;
                    prpu_pkg::REG_PLANE_COUNT:
                        plane_count_reg <= cfg_data[prpu_pkg::PLANE_W-1:0];
                    prpu_pkg::REG_LAYOUT_MODE:
                        layout_mode_reg <= cfg_data[0];
                    default:
                        layout_mode_reg <= layout_mode_reg;
                endcase
            end
        end
    end

    // The plane size is registered from the configuration; emission waits for it.
    always_ff @(posedge clk)
    begin
        plane_size_reg <= AW'(eff_w * eff_h);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_pending_reg <= 1'b0;
            run_length_reg    <= '0;
            count_reg         <= '0;
            column_reg        <= '0;
            plane_index_reg   <= '0;
            row_index_reg     <= '0;
            row_base_reg      <= '0;
            finished_reg      <= 1'b0;
        end
        else
        begin
            if (cmd.take_byte && !finished_reg)
            begin
                priority if (value_pending_reg)
                begin
                    value_pending_reg <= 1'b0;
                    count_reg         <= run_length_reg;
                end
                else if (is_header)
                begin
                    value_pending_reg <= 1'b1;
                    run_length_reg    <= prpu_pkg::RUN_W'(code_byte & prpu_pkg::COUNT_MASK);
                end
                else
                begin
                    count_reg <= prpu_pkg::RUN_W'(1);
                end
            end
            if (cmd.emit)
            begin
                count_reg <= count_reg - 1'b1;
                if (line_end)
                begin
                    column_reg <= '0;
                    if (row_end)
                    begin
                        plane_index_reg <= '0;
                        if (image_end)
                        begin
                            finished_reg <= 1'b1;
                        end
                        else
                        begin
                            row_index_reg <= row_inc[RW-1:0];
                            row_base_reg  <= row_base_reg + AW'(eff_w);
                        end
                    end
                    else
                    begin
                        plane_index_reg <= plane_inc;
                    end
                end
                else
                begin
                    column_reg <= col_inc[CW-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_byte && !finished_reg && (value_pending_reg || !is_header))
        begin
            value_reg <= code_byte;
        end
        if (cmd.emit)
        begin
            addr_reg  <= address;
            pixel_reg <= value_reg;
            last_reg  <= status.last_pixel;
            done_reg  <= image_end;
        end
    end

    assign write_address = addr_reg;
    assign pixel_value   = pixel_reg;
    assign last_of_run   = last_reg;
    assign image_done    = done_reg;

endmodule
`default_nettype wire

// ===== rtl/core/pcx_rle_plane_unpacker_top.sv =====
// Top level of the PCX run-length plane unpacker.
//
// Compressed bytes enter on the code channel, one per transaction. Decoded
// pixels leave on the pixel channel, each with its frame-buffer byte address,
// a flag on the last pixel that a byte produces and a flag on the last pixel
// of the image. Registers are to be written through the plain write port only
// while the block is idle; the block itself does not enforce this. A write
// holds pixel emission back in the cycle after it.
// A run header is taken and produces nothing. A literal byte is taken and
// then its pixel is emitted; the value byte after a header is taken and
// then its run is emitted. The controller emits at most one pixel per cycle
// and takes no byte while a run is being expanded.
// A registered result appears in the cycle after its emission and stays until
// taken. When the receiver stalls, emission pauses with the run position held.
// Reset clears the decode position and restores the register defaults. Once
// the last pixel of the image is out, further bytes are taken and dropped.
`default_nettype none
module pcx_rle_plane_unpacker_top #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    prpu_code_if.sink                               code,
    prpu_pixel_if.source                            pixel,
    input  wire logic                               cfg_we,
    input  wire logic [prpu_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [prpu_pkg::CFG_DATA_W-1:0]    cfg_data
);

    prpu_pkg::prpu_cmd_t    cmd;
    prpu_pkg::prpu_status_t status;

    prpu_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .code_valid (code.valid),
        .code_ready (code.ready),
        .out_valid  (pixel.valid),
        .out_ready  (pixel.ready),
        .status     (status),
        .cmd        (cmd)
    );

    prpu_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .code_byte     (code.code_byte),
        .cmd           (cmd),
        .status        (status),
        .write_address (pixel.write_address),
        .pixel_value   (pixel.pixel_value),
        .last_of_run   (pixel.last_of_run),
        .image_done    (pixel.image_done)
    );

endmodule
`default_nettype wire
